### design/uf2hv_pkg.sv
// Package for the UF2 block header validator.
// Holds the transaction structs, configuration codes, status codes and header constants.
// Has no dependencies; every design file uses it by scoped names.
`default_nettype none

package uf2hv_pkg;

  // Fixed words that every valid UF2 block carries.
  localparam logic [31:0] MagicFirst   = 32'h0A32_4655;
  localparam logic [31:0] MagicSecond  = 32'h9E5D_5157;
  localparam logic [31:0] MagicClosing = 32'h0AB1_6F30;

  // Bit positions in the block flags word.
  localparam int unsigned FlagNotMainBit   = 0;
  localparam int unsigned FlagContainerBit = 12;
  localparam int unsigned FlagFamilyBit    = 13;

  // Configuration register values after reset.
  localparam logic [31:0] FamilyCodeReset   = 32'hE48B_FF59;
  localparam logic [31:0] FlashBaseReset    = 32'h1000_0000;
  localparam logic [9:0]  PayloadLimitReset = 10'd476;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_FAMILY_CODE   = 2'd0,
    CFG_FLASH_BASE    = 2'd1,
    CFG_PAYLOAD_LIMIT = 2'd2
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_STARTED  = 4'd0,
    ST_SKIPPED  = 4'd1,
    ST_ACCEPTED = 4'd2,
    ST_COMPLETE = 4'd3,
    ST_ZERO     = 4'd4,
    ST_FOREIGN  = 4'd5,
    ST_BIG      = 4'd6,
    ST_BELOW    = 4'd7,
    ST_SHORT    = 4'd8,
    ST_IGNORED  = 4'd9
  } status_e;

  // Input command codes.
  localparam logic CmdStart  = 1'b0;
  localparam logic CmdHeader = 1'b1;

  // Current configuration, handed from the register file to the checker.
  typedef struct packed {
    logic [31:0] family_code;
    logic [31:0] flash_base;
    logic [9:0]  payload_limit;
  } cfg_t;

  // One input transaction: a command and the header words of one block.
  typedef struct packed {
    logic        command;
    logic        short_read;
    logic [31:0] magic_first;
    logic [31:0] magic_second;
    logic [31:0] flag_bits;
    logic [31:0] target_address;
    logic [31:0] payload_bytes;
    logic [31:0] total_blocks;
    logic [31:0] family_word;
    logic [31:0] magic_closing;
  } in_item_t;

  // One result transaction: the status and the tracking state after the step.
  typedef struct packed {
    status_e     status;
    logic [31:0] low_address;
    logic [31:0] high_offset;
    logic [31:0] image_start_block;
    logic [31:0] blocks_checked;
  } out_item_t;

endpackage

`default_nettype wire

### design/uf2_block_header_validator.sv
// UF2 block header validator, top level.
// Usage:
//   The input channel carries one transaction per command: a start command, which
//   clears the tracking state and arms the checker, or one block header.
//   The output channel returns exactly one result transaction per input
//   transaction, in order: a status code and the tracking values after the step.
//   Configuration (family code, flash base, payload limit) is written through a
//   plain write port while no transaction is in flight.
// Timing:
//   A transaction passes through the input register, then through the checker
//   into the result register.
//   Throughput is one transaction per cycle while the result is not stalled;
//   the checker is one pass of compares, 32-bit adds/subtracts and a min/max update.
// Reset:
//   Reset empties both registers, disarms the checker, clears the tracking
//   values and loads the configuration defaults.
// Stalls:
//   A stalled result holds; the input register still takes one more transaction
//   and then stalls the input side until the result is taken.
// Depends on uf2hv_pkg, uf2hv_cfg_regs, uf2hv_in_stage and uf2hv_check.
`default_nettype none

module uf2_block_header_validator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [uf2hv_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [uf2hv_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  input  wire logic                                in_valid_i,
  input  wire uf2hv_pkg::in_item_t                 in_data_i,
  output logic                                     in_stall_o,
  output logic                                     out_valid_o,
  output uf2hv_pkg::out_item_t                     out_data_o,
  input  wire logic                                out_stall_i
);

  uf2hv_pkg::cfg_t     cfg;
  uf2hv_pkg::in_item_t item;
  logic                item_valid;
  logic                take;

  uf2hv_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uf2hv_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  uf2hv_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

`ifndef SYNTHESIS
  // The input side stalls only because a result is waiting on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A start result always shows cleared tracking values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == uf2hv_pkg::ST_STARTED) |->
    (out_data_o.low_address == 32'd0 && out_data_o.high_offset == 32'd0 &&
     out_data_o.image_start_block == 32'd0 && out_data_o.blocks_checked == 32'd0))
    else $error("start result with stale tracking values");

  // Blocks are skipped only before any image block was validated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == uf2hv_pkg::ST_SKIPPED) |->
    (out_data_o.blocks_checked == 32'd0))
    else $error("skip reported after image blocks were checked");

  // Completion needs at least one validated block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == uf2hv_pkg::ST_COMPLETE) |->
    (out_data_o.blocks_checked != 32'd0))
    else $error("completion reported with no checked blocks");
`endif

endmodule

`default_nettype wire

### design/uf2hv_cfg_regs.sv
// Configuration register file of the UF2 block header validator.
// Depends on uf2hv_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module uf2hv_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [uf2hv_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [uf2hv_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  output uf2hv_pkg::cfg_t                          cfg_o
);

  uf2hv_pkg::cfg_t cfg_q;

  // Decode the index and update the addressed register; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_code   <= uf2hv_pkg::FamilyCodeReset;
      cfg_q.flash_base    <= uf2hv_pkg::FlashBaseReset;
      cfg_q.payload_limit <= uf2hv_pkg::PayloadLimitReset;
    end else if (cfg_we_i) begin
      unique case (uf2hv_pkg::cfg_idx_e'(cfg_idx_i))
        uf2hv_pkg::CFG_FAMILY_CODE:   cfg_q.family_code   <= cfg_wdata_i;
        uf2hv_pkg::CFG_FLASH_BASE:    cfg_q.flash_base    <= cfg_wdata_i;
        uf2hv_pkg::CFG_PAYLOAD_LIMIT: cfg_q.payload_limit <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/uf2hv_in_stage.sv
// Input register of the UF2 block header validator.
// Holds one accepted transaction until the checker takes it; depends on uf2hv_pkg.
`default_nettype none

module uf2hv_in_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire uf2hv_pkg::in_item_t  in_data_i,
  output logic                      in_stall_o,
  input  wire logic                 take_i,
  output logic                      item_valid_o,
  output uf2hv_pkg::in_item_t       item_o
);

  logic                valid_q;
  uf2hv_pkg::in_item_t data_q;

  // The register stalls only while it is full and the checker cannot take it.
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // The payload needs no reset; it loads whenever a new transaction comes in.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

`default_nettype wire

### design/uf2hv_check.sv
// Header checker and tracking state of the UF2 block header validator.
// Validates one header per cycle unless the result stalls, updates the tracking state and registers the result.
// Depends on uf2hv_pkg.
`default_nettype none

module uf2hv_check (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire uf2hv_pkg::cfg_t      cfg_i,
  input  wire logic                 item_valid_i,
  input  wire uf2hv_pkg::in_item_t  item_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  output uf2hv_pkg::out_item_t      out_data_o,
  input  wire logic                 out_stall_i
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] expected_q, expected_d;
  logic [31:0] checked_q, checked_d;
  logic [31:0] lowest_q, lowest_d;
  logic [31:0] highest_q, highest_d;
  logic [31:0] start_q, start_d;
  uf2hv_pkg::status_e status_d;

  logic                 out_valid_q;
  uf2hv_pkg::out_item_t out_data_q;

  logic        block_match;
  logic        first_block;
  logic [31:0] low_base;
  logic [31:0] end_off;
  logic [31:0] checked_inc;

  // A transaction moves on when the result register is empty or being drained.
  assign take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  // A block belongs to the image when its magic words, flags and family all fit.
  assign block_match = (item_i.magic_first == uf2hv_pkg::MagicFirst)
                    && (item_i.magic_second == uf2hv_pkg::MagicSecond)
                    && item_i.flag_bits[uf2hv_pkg::FlagFamilyBit]
                    && !item_i.flag_bits[uf2hv_pkg::FlagNotMainBit]
                    && !item_i.flag_bits[uf2hv_pkg::FlagContainerBit]
                    && (item_i.family_word == cfg_i.family_code)
                    && (item_i.magic_closing == uf2hv_pkg::MagicClosing);

  assign first_block = (expected_q == 32'd0);
  assign low_base    = first_block ? item_i.target_address : lowest_q;
  assign end_off     = item_i.target_address - cfg_i.flash_base + item_i.payload_bytes;
  assign checked_inc = checked_q + 32'd1;

  // Next tracking state and status for the transaction in the input register.
  always_comb begin
    phase_d    = phase_q;
    expected_d = expected_q;
    checked_d  = checked_q;
    lowest_d   = lowest_q;
    highest_d  = highest_q;
    start_d    = start_q;
    status_d   = uf2hv_pkg::ST_IGNORED;
    if (item_i.command == uf2hv_pkg::CmdStart) begin
      phase_d    = PH_RUN;
      expected_d = 32'd0;
      checked_d  = 32'd0;
      lowest_d   = 32'd0;
      highest_d  = 32'd0;
      start_d    = 32'd0;
      status_d   = uf2hv_pkg::ST_STARTED;
    end else if (phase_q != PH_RUN) begin
      status_d = uf2hv_pkg::ST_IGNORED;
    end else if (item_i.short_read) begin
      phase_d  = PH_IDLE;
      status_d = uf2hv_pkg::ST_SHORT;
    end else if (first_block && !block_match) begin
      // Still searching for the image: count the skipped block.
      start_d  = start_q + 32'd1;
      status_d = uf2hv_pkg::ST_SKIPPED;
    end else if (first_block && (item_i.total_blocks == 32'd0)) begin
      phase_d  = PH_IDLE;
      status_d = uf2hv_pkg::ST_ZERO;
    end else begin
      // The first image block latches the count and start address, even if it fails later.
      expected_d = first_block ? item_i.total_blocks : expected_q;
      lowest_d   = low_base;
      if (!block_match) begin
        phase_d  = PH_IDLE;
        status_d = uf2hv_pkg::ST_FOREIGN;
      end else if (item_i.payload_bytes > {22'd0, cfg_i.payload_limit}) begin
        phase_d  = PH_IDLE;
        status_d = uf2hv_pkg::ST_BIG;
      end else if (item_i.target_address < cfg_i.flash_base) begin
        phase_d  = PH_IDLE;
        status_d = uf2hv_pkg::ST_BELOW;
      end else begin
        if (end_off > highest_q) begin
          highest_d = end_off;
        end
        if (item_i.target_address < low_base) begin
          lowest_d = item_i.target_address;
        end
        checked_d = checked_inc;
        if (checked_inc >= expected_d) begin
          phase_d  = PH_DONE;
          status_d = uf2hv_pkg::ST_COMPLETE;
        end else begin
          status_d = uf2hv_pkg::ST_ACCEPTED;
        end
      end
    end
  end

  // State, tracking values and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      expected_q  <= 32'd0;
      checked_q   <= 32'd0;
      lowest_q    <= 32'd0;
      highest_q   <= 32'd0;
      start_q     <= 32'd0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (take_o) begin
      phase_q                      <= phase_d;
      expected_q                   <= expected_d;
      checked_q                    <= checked_d;
      lowest_q                     <= lowest_d;
      highest_q                    <= highest_d;
      start_q                      <= start_d;
      out_valid_q                  <= 1'b1;
      out_data_q.status            <= status_d;
      out_data_q.low_address       <= lowest_d;
      out_data_q.high_offset       <= highest_d;
      out_data_q.image_start_block <= start_d;
      out_data_q.blocks_checked    <= checked_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
